/* src/bptm_pkg.sv */
package bptm_pkg;

    localparam int BPTM_TOTAL_LIMIT = 4;
    localparam int BPTM_CODE_DEPTH  = 4;
    localparam int BPTM_DATA_DEPTH  = 2;

    typedef enum logic [2:0] {
        K_ADD = 3'd0,
        K_DEL = 3'd1,
        K_CLR = 3'd2,
        K_QAT = 3'd3,
        K_QBT = 3'd4,
        K_UPD = 3'd5
    } kind_t;

    localparam logic [1:0] BP_CODE = 2'd0;
    localparam logic [1:0] TC_CODE = 2'd3;

    typedef struct packed {
        logic load;
        logic add;
        logic clear;
        logic step;
        logic shift;
        logic set_hit;
        logic slot_step;
        logic out_load;
    } bptm_ctl_t;

    typedef struct packed {
        kind_t kind;
        logic  scan_end;
        logic  match;
        logic  slot_last;
        logic  out_free;
    } bptm_st_t;

    // Slot type code: read 0, write 1, access 2, code 3.
    function automatic logic [1:0] slot_tcode(input logic [1:0] bp_type);
        logic [1:0] tc;
        if (bp_type == BP_CODE)
            tc = TC_CODE;
        else
            tc = bp_type - 2'd1;
        return tc;
    endfunction

endpackage

/* src/bptm_if.sv */
interface bptm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [16:0] address;
    logic [16:0] end_address;
    logic [1:0]  bp_type;

    modport source (output valid, kind, address, end_address, bp_type, input ready);
    modport sink   (input valid, kind, address, end_address, bp_type, output ready);
endinterface

interface bptm_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic        hit;
    logic        z0_valid;
    logic [15:0] z0_address;
    logic        z1_valid;
    logic [15:0] z1_address;
    logic        x_valid;
    logic [15:0] x_address;
    logic        y_valid;
    logic [15:0] y_address;
    logic [5:0]  mode;

    modport source (
        output valid, ok, hit, z0_valid, z0_address, z1_valid, z1_address,
               x_valid, x_address, y_valid, y_address, mode,
        input  ready
    );
    modport sink (
        input  valid, ok, hit, z0_valid, z0_address, z1_valid, z1_address,
               x_valid, x_address, y_valid, y_address, mode,
        output ready
    );
endinterface

/* src/breakpoint_table_manager.sv */
// Breakpoint table manager: code and typed data breakpoint tables with slot mapping.
// req channel (valid/ready) carries one command word: kind, address, end_address,
// bp_type. rsp channel (valid/ready) returns exactly one result word per command:
// ok, hit, the Z0/Z1/X/Y slot assignments and the 6-bit mode field.
// One command is in flight at a time; req.ready is high only while the controller
// is idle. Steps from acceptance to the loaded result:
//   add, clear, unused kinds : the execute state, then the done state
//   delete, query at/between : a scan of the code (or data) table to a match, one
//                              table entry compared per cycle by the scan pointer
//   update slots             : one slot filled per cycle, Z0, Z1, X, then Y
// The next command is taken the cycle after the result is loaded.
// The result sits in an output register: the next command is accepted and worked
// on while the previous result waits for rsp.ready; a finished result then waits
// in the controller until the register frees.
// Reset (rst_n low, asynchronous) empties both tables and drops rsp.valid; entries
// are only read below the fill counts, so the tables themselves need no clearing.
module breakpoint_table_manager
    import bptm_pkg::*;
#(
    parameter int TOTAL_LIMIT = BPTM_TOTAL_LIMIT,
    parameter int CODE_DEPTH  = BPTM_CODE_DEPTH,
    parameter int DATA_DEPTH  = BPTM_DATA_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    bptm_req_if.sink   req,
    bptm_rsp_if.source rsp
);

    bptm_ctl_t ctl;
    bptm_st_t  st;

    bptm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .ctl       (ctl),
        .st        (st)
    );

    bptm_dpath #(
        .TOTAL_LIMIT (TOTAL_LIMIT),
        .CODE_DEPTH  (CODE_DEPTH),
        .DATA_DEPTH  (DATA_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (req.kind),
        .address     (req.address),
        .end_address (req.end_address),
        .bp_type     (req.bp_type),
        .ctl         (ctl),
        .st          (st),
        .rsp         (rsp)
    );

endmodule

/* src/bptm_ctrl.sv */
module bptm_ctrl
    import bptm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output bptm_ctl_t ctl,
    input  bptm_st_t  st
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_SLOT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (st.kind)
                    K_ADD:
                    begin
                        ctl.add    = 1'b1;
                        state_next = S_DONE;
                    end
                    K_CLR:
                    begin
                        ctl.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    K_DEL, K_QAT, K_QBT: state_next = S_SCAN;
                    K_UPD:               state_next = S_SLOT;
                    default:             state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                if (st.scan_end)
                    state_next = S_DONE;
                else if (st.match)
                begin
                    if (st.kind == K_DEL)
                        ctl.shift = 1'b1;
                    else
                        ctl.set_hit = 1'b1;
                    state_next = S_DONE;
                end
                else
                    ctl.step = 1'b1;
            end
            S_SLOT:
            begin
                ctl.slot_step = 1'b1;
                if (st.slot_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* src/bptm_dpath.sv */
module bptm_dpath
    import bptm_pkg::*;
#(
    parameter int TOTAL_LIMIT = BPTM_TOTAL_LIMIT,
    parameter int CODE_DEPTH  = BPTM_CODE_DEPTH,
    parameter int DATA_DEPTH  = BPTM_DATA_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  kind,
    input  logic [16:0] address,
    input  logic [16:0] end_address,
    input  logic [1:0]  bp_type,
    input  bptm_ctl_t   ctl,
    output bptm_st_t    st,
    bptm_rsp_if.source  rsp
);

    localparam int CCW   = $clog2(CODE_DEPTH + 1);
    localparam int DCW   = $clog2(DATA_DEPTH + 1);
    localparam int CIW   = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
    localparam int DIW   = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int SUM_W = $clog2(CODE_DEPTH + DATA_DEPTH + TOTAL_LIMIT + 1);

    kind_t       kind_reg;
    logic [16:0] addr_reg;
    logic [16:0] end_reg;
    logic [1:0]  type_reg;

    logic [15:0] code_table [CODE_DEPTH];
    logic [17:0] data_table [DATA_DEPTH];

    logic [CCW-1:0] code_cnt_reg;
    logic [DCW-1:0] data_cnt_reg;
    logic [CCW-1:0] ci_reg;
    logic [DCW-1:0] di_reg;
    logic [1:0]     slot_reg;

    logic        ok_reg;
    logic        hit_reg;
    logic        z0v_reg;
    logic [15:0] z0a_reg;
    logic        z1v_reg;
    logic [15:0] z1a_reg;
    logic        xv_reg;
    logic [15:0] xa_reg;
    logic [1:0]  xt_reg;
    logic        yv_reg;
    logic [15:0] ya_reg;
    logic [1:0]  yt_reg;

    logic        out_valid_reg;
    logic        o_ok_reg;
    logic        o_hit_reg;
    logic        o_z0v_reg;
    logic [15:0] o_z0a_reg;
    logic        o_z1v_reg;
    logic [15:0] o_z1a_reg;
    logic        o_xv_reg;
    logic [15:0] o_xa_reg;
    logic        o_yv_reg;
    logic [15:0] o_ya_reg;
    logic [5:0]  o_mode_reg;

    logic [15:0] code_word;
    logic [17:0] data_word;
    logic [15:0] waddr;
    logic [15:0] wend;
    logic [17:0] dkey;
    logic        use_data;
    logic        code_av;
    logic        data_av;
    logic        add_ok;
    logic        add_code;
    logic        add_data;
    logic        out_free;
    logic [15:0] pick_addr;
    logic [1:0]  pick_tc;

    assign code_word = code_table[ci_reg[CIW-1:0]];
    assign data_word = data_table[di_reg[DIW-1:0]];
    assign waddr     = addr_reg[16:1];
    assign wend      = end_reg[16:1];
    assign dkey      = {type_reg, addr_reg[15:0]};
    assign use_data  = (kind_reg == K_DEL) && (type_reg != BP_CODE);
    assign code_av   = ci_reg < code_cnt_reg;
    assign data_av   = di_reg < data_cnt_reg;
    assign add_ok    = (SUM_W'(code_cnt_reg) + SUM_W'(data_cnt_reg)) < SUM_W'(TOTAL_LIMIT);
    assign add_code  = add_ok && (type_reg == BP_CODE) && (code_cnt_reg != CCW'(CODE_DEPTH));
    assign add_data  = add_ok && (type_reg != BP_CODE) && (data_cnt_reg != DCW'(DATA_DEPTH));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign pick_addr = code_av ? code_word : data_word[15:0];
    assign pick_tc   = code_av ? TC_CODE : slot_tcode(data_word[17:16]);

    always_comb
    begin
        st.kind      = kind_reg;
        st.scan_end  = use_data ? !data_av : !code_av;
        st.slot_last = slot_reg == 2'd3;
        st.out_free  = out_free;
        case (kind_reg)
            K_DEL:   st.match = use_data ? (data_word == dkey) : (code_word == waddr);
            K_QAT:   st.match = code_word == waddr;
            K_QBT:   st.match = (code_word >= waddr) && (code_word < wend);
            default: st.match = 1'b0;
        endcase
    end

    // hold the command kind, counts, scan pointers and slot counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= K_ADD;
            code_cnt_reg <= '0;
            data_cnt_reg <= '0;
            ci_reg       <= '0;
            di_reg       <= '0;
            slot_reg     <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                kind_reg <= kind_t'(kind);
                ci_reg   <= '0;
                di_reg   <= '0;
                slot_reg <= '0;
            end
            if (ctl.add && add_code)
                code_cnt_reg <= code_cnt_reg + CCW'(1);
            if (ctl.add && add_data)
                data_cnt_reg <= data_cnt_reg + DCW'(1);
            if (ctl.clear)
            begin
                code_cnt_reg <= '0;
                data_cnt_reg <= '0;
            end
            if (ctl.shift)
            begin
                if (use_data)
                    data_cnt_reg <= data_cnt_reg - DCW'(1);
                else
                    code_cnt_reg <= code_cnt_reg - CCW'(1);
            end
            if (ctl.step)
            begin
                if (use_data)
                    di_reg <= di_reg + DCW'(1);
                else
                    ci_reg <= ci_reg + CCW'(1);
            end
            if (ctl.slot_step)
            begin
                slot_reg <= slot_reg + 2'd1;
                if (code_av)
                    ci_reg <= ci_reg + CCW'(1);
                else if (data_av && slot_reg[1])
                    di_reg <= di_reg + DCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            addr_reg <= address;
            end_reg  <= end_address;
            type_reg <= bp_type;
            ok_reg   <= 1'b0;
            hit_reg  <= 1'b0;
            z0v_reg  <= 1'b0;
            z0a_reg  <= '0;
            z1v_reg  <= 1'b0;
            z1a_reg  <= '0;
            xv_reg   <= 1'b0;
            xa_reg   <= '0;
            xt_reg   <= '0;
            yv_reg   <= 1'b0;
            ya_reg   <= '0;
            yt_reg   <= '0;
        end
        if ((ctl.add && (add_code || add_data)) || ctl.clear || ctl.shift || ctl.slot_step)
            ok_reg <= 1'b1;
        if (ctl.set_hit)
            hit_reg <= 1'b1;
        if (ctl.slot_step)
        begin
            case (slot_reg)
                2'd0:
                begin
                    z0v_reg <= code_av;
                    z0a_reg <= code_av ? code_word : 16'd0;
                end
                2'd1:
                begin
                    z1v_reg <= code_av;
                    z1a_reg <= code_av ? code_word : 16'd0;
                end
                2'd2:
                begin
                    if (code_av || data_av)
                    begin
                        xv_reg <= 1'b1;
                        xa_reg <= pick_addr;
                        xt_reg <= pick_tc;
                    end
                end
                default:
                begin
                    if (code_av || data_av)
                    begin
                        yv_reg <= 1'b1;
                        ya_reg <= pick_addr;
                        yt_reg <= pick_tc;
                    end
                end
            endcase
        end
    end

    // append on add, close the gap on delete
    for (genvar k = 0; k < CODE_DEPTH; k++)
    begin : g_code
        if (k < CODE_DEPTH - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (ctl.add && add_code && (code_cnt_reg == CCW'(k)))
                    code_table[k] <= waddr;
                else if (ctl.shift && !use_data && (ci_reg <= CCW'(k)))
                    code_table[k] <= code_table[k + 1];
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (ctl.add && add_code && (code_cnt_reg == CCW'(k)))
                    code_table[k] <= waddr;
            end
        end
    end

    for (genvar k = 0; k < DATA_DEPTH; k++)
    begin : g_data
        if (k < DATA_DEPTH - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (ctl.add && add_data && (data_cnt_reg == DCW'(k)))
                    data_table[k] <= dkey;
                else if (ctl.shift && use_data && (di_reg <= DCW'(k)))
                    data_table[k] <= data_table[k + 1];
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (ctl.add && add_data && (data_cnt_reg == DCW'(k)))
                    data_table[k] <= dkey;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            o_ok_reg   <= ok_reg;
            o_hit_reg  <= hit_reg;
            o_z0v_reg  <= z0v_reg;
            o_z0a_reg  <= z0a_reg;
            o_z1v_reg  <= z1v_reg;
            o_z1a_reg  <= z1a_reg;
            o_xv_reg   <= xv_reg;
            o_xa_reg   <= xa_reg;
            o_yv_reg   <= yv_reg;
            o_ya_reg   <= ya_reg;
            o_mode_reg <= {xv_reg, yv_reg, xt_reg, yt_reg};
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = o_ok_reg;
    assign rsp.hit        = o_hit_reg;
    assign rsp.z0_valid   = o_z0v_reg;
    assign rsp.z0_address = o_z0a_reg;
    assign rsp.z1_valid   = o_z1v_reg;
    assign rsp.z1_address = o_z1a_reg;
    assign rsp.x_valid    = o_xv_reg;
    assign rsp.x_address  = o_xa_reg;
    assign rsp.y_valid    = o_yv_reg;
    assign rsp.y_address  = o_ya_reg;
    assign rsp.mode       = o_mode_reg;

    a_code_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        code_cnt_reg <= CCW'(CODE_DEPTH))
        else $error("code count beyond table depth");

    a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        data_cnt_reg <= DCW'(DATA_DEPTH))
        else $error("data count beyond table depth");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(code_cnt_reg) + SUM_W'(data_cnt_reg)) <= SUM_W'(TOTAL_LIMIT))
        else $error("breakpoint total beyond limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || rsp.ready))
        else $error("pending result overwritten");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> ((!o_yv_reg || o_xv_reg) && (!o_z1v_reg || o_z0v_reg)))
        else $error("slot assigned out of order");

endmodule
